/* src/bcrs_pkg.sv */
// Shared types and constants for the best chi-square rotation selector.
`timescale 1ns / 1ps
`default_nettype none
package bcrs_pkg;

    localparam int ROTATIONS = 3;
    localparam int ROT_W     = (ROTATIONS > 1) ? $clog2(ROTATIONS) : 1;

    localparam int MASS_W    = 20;
    localparam int CFG_W     = 20;
    localparam int WEIGHT_W  = 32;
    localparam int SCORE_W   = 63;
    localparam int CFG_IDX_W = 4;

    // Shared multiplier: operands are MUL_W bits, the scaled distance is P_W bits
    // and is squared from its two halves.
    localparam int MUL_W   = 20;
    localparam int P_W     = 2 * MUL_W;
    localparam int ACC_W   = 2 * P_W;
    localparam int FRAC_SH = 16;
    localparam int LH_SH   = MUL_W + 1;
    localparam int HH_SH   = 2 * MUL_W;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PI0_CENTER  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SIG_PI0 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_CENTER  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SIG_ETA = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PI0_WIN_LO  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PI0_WIN_HI  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_WIN_LO  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_WIN_HI  = 4'd7;

    localparam logic [CFG_W-1:0] RST_PI0_CENTER  = 20'd8847;
    localparam logic [CFG_W-1:0] RST_INV_SIG_PI0 = 20'd25600;
    localparam logic [CFG_W-1:0] RST_ETA_CENTER  = 20'd35848;
    localparam logic [CFG_W-1:0] RST_INV_SIG_ETA = 20'd5120;
    localparam logic [CFG_W-1:0] RST_PI0_WIN_LO  = 20'd8192;
    localparam logic [CFG_W-1:0] RST_PI0_WIN_HI  = 20'd9503;
    localparam logic [CFG_W-1:0] RST_ETA_WIN_LO  = 20'd32768;
    localparam logic [CFG_W-1:0] RST_ETA_WIN_HI  = 20'd39322;

    typedef struct packed {
        logic [CFG_W-1:0] pi0_center;
        logic [CFG_W-1:0] inv_sig_pi0;
        logic [CFG_W-1:0] eta_center;
        logic [CFG_W-1:0] inv_sig_eta;
        logic [CFG_W-1:0] pi0_win_lo;
        logic [CFG_W-1:0] pi0_win_hi;
        logic [CFG_W-1:0] eta_win_lo;
        logic [CFG_W-1:0] eta_win_hi;
    } cfg_t;

    // One candidate word, tagged with its place in the group
    typedef struct packed {
        logic                first;
        logic                last;
        logic [MASS_W-1:0]   eta;
        logic [MASS_W-1:0]   pi0;
        logic [MASS_W-1:0]   tot;
        logic [WEIGHT_W-1:0] weight;
    } item_t;

    // Queue status to the front and back end
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic [MASS_W-1:0] abs_diff(input logic [MASS_W-1:0] a,
                                                   input logic [MASS_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage
`default_nettype wire

/* src/bcrs_front.sv */
// Front end: accepts candidate words and tags first/last rotation of a group.
`timescale 1ns / 1ps
`default_nettype none
module bcrs_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [bcrs_pkg::MASS_W-1:0]   eta_pair_mass,
    input  wire logic [bcrs_pkg::MASS_W-1:0]   pi0_pair_mass,
    input  wire logic [bcrs_pkg::MASS_W-1:0]   total_mass,
    input  wire logic [bcrs_pkg::WEIGHT_W-1:0] weight,
    input  wire bcrs_pkg::queue_stat_t         qstat,
    output logic                               push,
    output bcrs_pkg::item_t                    push_item
);

    logic [bcrs_pkg::ROT_W-1:0] rot_reg;
    logic [bcrs_pkg::ROT_W-1:0] rot_next;
    logic                       is_last;

    assign in_stall = qstat.full;
    assign push     = in_valid && !qstat.full;
    assign is_last  = (rot_reg == bcrs_pkg::ROT_W'(bcrs_pkg::ROTATIONS - 1));

    always_comb
    begin
        push_item.first  = (rot_reg == '0);
        push_item.last   = is_last;
        push_item.eta    = eta_pair_mass;
        push_item.pi0    = pi0_pair_mass;
        push_item.tot    = total_mass;
        push_item.weight = weight;
    end

    always_comb
    begin
        rot_next = rot_reg;
        if (push)
        begin
            rot_next = is_last ? '0 : rot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg <= '0;
        end
        else
        begin
            rot_reg <= rot_next;
        end
    end

endmodule
`default_nettype wire

/* src/bcrs_queue.sv */
// Short word queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module bcrs_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire bcrs_pkg::item_t       push_item,
    input  wire logic                  pop,
    output bcrs_pkg::item_t            head,
    output bcrs_pkg::queue_stat_t      qstat
);

    bcrs_pkg::item_t                  mem_reg [bcrs_pkg::QUEUE_DEPTH];
    logic [bcrs_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [bcrs_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [bcrs_pkg::QCNT_W-1:0]      count_reg;
    logic [bcrs_pkg::QCNT_W-1:0]      count_next;

    assign qstat.full  = (count_reg == bcrs_pkg::QCNT_W'(bcrs_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

/* src/bcrs_back.sv */
// Back end: scores one candidate on a shared multiplier and keeps the group minimum.
`timescale 1ns / 1ps
`default_nettype none
module bcrs_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bcrs_pkg::cfg_t                cfg,
    input  wire bcrs_pkg::item_t               head,
    input  wire bcrs_pkg::queue_stat_t         qstat,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               accepted,
    output logic [bcrs_pkg::MASS_W-1:0]        selected_total_mass,
    output logic [bcrs_pkg::WEIGHT_W-1:0]      selected_weight,
    output logic [bcrs_pkg::SCORE_W-1:0]       selected_score
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MULP   = 8'b0000_0010,
        S_SQ_LL  = 8'b0000_0100,
        S_SQ_LH  = 8'b0000_1000,
        S_SQ_HH  = 8'b0001_0000,
        S_SQ_ACC = 8'b0010_0000,
        S_TERM   = 8'b0100_0000,
        S_UPDATE = 8'b1000_0000
    } state_t;

    state_t                               state_reg;
    state_t                               state_next;
    logic                                 term_sel_reg;   // 0: eta term, 1: pi0 term
    bcrs_pkg::item_t                      item_reg;
    logic [bcrs_pkg::MASS_W-1:0]          d_eta_reg;
    logic [bcrs_pkg::MASS_W-1:0]          d_pi0_reg;
    logic [bcrs_pkg::P_W-1:0]             p_reg;
    logic [bcrs_pkg::P_W-1:0]             prod_reg;
    logic [bcrs_pkg::ACC_W-1:0]           acc_reg;
    logic [bcrs_pkg::SCORE_W-1:0]         score_reg;

    logic [bcrs_pkg::SCORE_W-1:0]         best_score_reg;
    logic [bcrs_pkg::MASS_W-1:0]          best_eta_reg;
    logic [bcrs_pkg::MASS_W-1:0]          best_pi0_reg;
    logic [bcrs_pkg::MASS_W-1:0]          best_tot_reg;
    logic [bcrs_pkg::WEIGHT_W-1:0]        best_weight_reg;

    logic                                 out_valid_reg;
    logic                                 accepted_reg;
    logic [bcrs_pkg::MASS_W-1:0]          sel_tot_reg;
    logic [bcrs_pkg::WEIGHT_W-1:0]        sel_weight_reg;
    logic [bcrs_pkg::SCORE_W-1:0]         sel_score_reg;

    logic [bcrs_pkg::MUL_W-1:0]           mul_a;
    logic [bcrs_pkg::MUL_W-1:0]           mul_b;
    logic [bcrs_pkg::P_W-1:0]             mul_p;
    logic [bcrs_pkg::MUL_W-1:0]           p_lo;
    logic [bcrs_pkg::MUL_W-1:0]           p_hi;
    logic [bcrs_pkg::SCORE_W-1:0]         term;
    logic [bcrs_pkg::SCORE_W:0]           score_sum;
    logic [bcrs_pkg::SCORE_W-1:0]         score_sat;

    logic                                 take;
    logic [bcrs_pkg::SCORE_W-1:0]         new_score;
    logic [bcrs_pkg::MASS_W-1:0]          new_eta;
    logic [bcrs_pkg::MASS_W-1:0]          new_pi0;
    logic [bcrs_pkg::MASS_W-1:0]          new_tot;
    logic [bcrs_pkg::WEIGHT_W-1:0]        new_weight;
    logic                                 win_ok;
    logic                                 out_free;
    logic                                 emit;
    logic                                 commit;

    assign p_lo = p_reg[bcrs_pkg::MUL_W-1:0];
    assign p_hi = p_reg[bcrs_pkg::P_W-1:bcrs_pkg::MUL_W];

    // single shared multiplier, operand select by step
    always_comb
    begin
        mul_a = p_lo;
        mul_b = p_lo;
        unique case (state_reg)
            S_MULP:
            begin
                mul_a = term_sel_reg ? d_pi0_reg : d_eta_reg;
                mul_b = term_sel_reg ? cfg.inv_sig_pi0 : cfg.inv_sig_eta;
            end
            S_SQ_LH:
            begin
                mul_a = p_hi;
                mul_b = p_lo;
            end
            S_SQ_HH:
            begin
                mul_a = p_hi;
                mul_b = p_hi;
            end
            default:
            begin
                mul_a = p_lo;
                mul_b = p_lo;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // floor(p^2 / 2^16), saturated
    assign term = (|acc_reg[bcrs_pkg::ACC_W-1:bcrs_pkg::FRAC_SH+bcrs_pkg::SCORE_W])
                  ? bcrs_pkg::SCORE_MAX
                  : acc_reg[bcrs_pkg::FRAC_SH+bcrs_pkg::SCORE_W-1:bcrs_pkg::FRAC_SH];

    assign score_sum = {1'b0, score_reg} + {1'b0, term};
    assign score_sat = score_sum[bcrs_pkg::SCORE_W] ? bcrs_pkg::SCORE_MAX
                                                    : score_sum[bcrs_pkg::SCORE_W-1:0];

    // running minimum; ties keep the earlier rotation
    assign take       = item_reg.first || (score_reg < best_score_reg);
    assign new_score  = take ? score_reg       : best_score_reg;
    assign new_eta    = take ? item_reg.eta    : best_eta_reg;
    assign new_pi0    = take ? item_reg.pi0    : best_pi0_reg;
    assign new_tot    = take ? item_reg.tot    : best_tot_reg;
    assign new_weight = take ? item_reg.weight : best_weight_reg;

    assign win_ok = (new_eta >= cfg.eta_win_lo) && (new_eta <= cfg.eta_win_hi) &&
                    (new_pi0 >= cfg.pi0_win_lo) && (new_pi0 <= cfg.pi0_win_hi);

    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (state_reg == S_UPDATE) && (!item_reg.last || out_free);
    assign emit     = commit && item_reg.last;
    assign pop      = (state_reg == S_IDLE) && !qstat.empty;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   state_next = qstat.empty ? S_IDLE : S_MULP;
            S_MULP:   state_next = S_SQ_LL;
            S_SQ_LL:  state_next = S_SQ_LH;
            S_SQ_LH:  state_next = S_SQ_HH;
            S_SQ_HH:  state_next = S_SQ_ACC;
            S_SQ_ACC: state_next = S_TERM;
            S_TERM:   state_next = term_sel_reg ? S_UPDATE : S_MULP;
            S_UPDATE: state_next = commit ? S_IDLE : S_UPDATE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            term_sel_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            best_score_reg  <= bcrs_pkg::SCORE_MAX;
            best_eta_reg    <= '0;
            best_pi0_reg    <= '0;
            best_tot_reg    <= '0;
            best_weight_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                term_sel_reg <= 1'b0;
            end
            else if (state_reg == S_TERM)
            begin
                term_sel_reg <= 1'b1;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (commit)
            begin
                if (item_reg.last)
                begin
                    best_score_reg <= bcrs_pkg::SCORE_MAX;
                end
                else
                begin
                    best_score_reg <= new_score;
                end
                best_eta_reg    <= new_eta;
                best_pi0_reg    <= new_pi0;
                best_tot_reg    <= new_tot;
                best_weight_reg <= new_weight;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg  <= head;
            d_eta_reg <= bcrs_pkg::abs_diff(head.eta, cfg.eta_center);
            d_pi0_reg <= bcrs_pkg::abs_diff(head.pi0, cfg.pi0_center);
        end
        unique case (state_reg)
            S_MULP:
            begin
                p_reg <= mul_p;
            end
            S_SQ_LL:
            begin
                prod_reg <= mul_p;
                acc_reg  <= '0;
            end
            S_SQ_LH:
            begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + bcrs_pkg::ACC_W'(prod_reg);
            end
            S_SQ_HH:
            begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + (bcrs_pkg::ACC_W'(prod_reg) << bcrs_pkg::LH_SH);
            end
            S_SQ_ACC:
            begin
                acc_reg <= acc_reg + (bcrs_pkg::ACC_W'(prod_reg) << bcrs_pkg::HH_SH);
            end
            S_TERM:
            begin
                score_reg <= term_sel_reg ? score_sat : term;
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            accepted_reg   <= win_ok;
            sel_tot_reg    <= new_tot;
            sel_weight_reg <= new_weight;
            sel_score_reg  <= new_score;
        end
    end

    assign out_valid           = out_valid_reg;
    assign accepted            = accepted_reg;
    assign selected_total_mass = sel_tot_reg;
    assign selected_weight     = sel_weight_reg;
    assign selected_score      = sel_score_reg;

endmodule
`default_nettype wire

/* src/best_chi2_rotation_selector.sv */
// Top level of the best chi-square rotation selector: config registers and front/queue/back.
//
//  Channel  | Signals                                            | Direction
//  ---------+----------------------------------------------------+----------
//  input    | in_valid, in_stall, eta/pi0_pair_mass, total_mass, | in
//           | weight                                             |
//  output   | out_valid, out_stall, accepted, selected_*         | out
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data          | in
//
// Each candidate word passes through the back end in order: it is popped and
// both mass distances are formed, then each chi-square term runs on the single
// shared 20x20 multiplier (scale, three partial squares, final add, saturate),
// and last the group minimum is updated. That multiplier sets the rate.
// A two-word queue lets the front take words while the back end is busy.
// One result word per group of ROTATIONS candidates, on the last one.
// Reset (rst_n, async, low) clears the rotation count, queue and output
// valid, so a partial group is dropped; config returns to defaults.
// out_stall holds the result register; the back end then waits in its
// update step only when it has a new result to write.
`timescale 1ns / 1ps
`default_nettype none
module best_chi2_rotation_selector (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [bcrs_pkg::MASS_W-1:0]       eta_pair_mass,
    input  wire logic [bcrs_pkg::MASS_W-1:0]       pi0_pair_mass,
    input  wire logic [bcrs_pkg::MASS_W-1:0]       total_mass,
    input  wire logic [bcrs_pkg::WEIGHT_W-1:0]     weight,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   accepted,
    output logic [bcrs_pkg::MASS_W-1:0]            selected_total_mass,
    output logic [bcrs_pkg::WEIGHT_W-1:0]          selected_weight,
    output logic [bcrs_pkg::SCORE_W-1:0]           selected_score,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bcrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bcrs_pkg::CFG_W-1:0]        cfg_data
);

    bcrs_pkg::cfg_t        cfg_reg;
    bcrs_pkg::item_t       push_item;
    bcrs_pkg::item_t       head;
    bcrs_pkg::queue_stat_t qstat;
    logic                  push;
    logic                  pop;

    // config writes always taken; indexes past the last register are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pi0_center  <= bcrs_pkg::RST_PI0_CENTER;
            cfg_reg.inv_sig_pi0 <= bcrs_pkg::RST_INV_SIG_PI0;
            cfg_reg.eta_center  <= bcrs_pkg::RST_ETA_CENTER;
            cfg_reg.inv_sig_eta <= bcrs_pkg::RST_INV_SIG_ETA;
            cfg_reg.pi0_win_lo  <= bcrs_pkg::RST_PI0_WIN_LO;
            cfg_reg.pi0_win_hi  <= bcrs_pkg::RST_PI0_WIN_HI;
            cfg_reg.eta_win_lo  <= bcrs_pkg::RST_ETA_WIN_LO;
            cfg_reg.eta_win_hi  <= bcrs_pkg::RST_ETA_WIN_HI;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bcrs_pkg::REG_PI0_CENTER:  cfg_reg.pi0_center  <= cfg_data;
                bcrs_pkg::REG_INV_SIG_PI0: cfg_reg.inv_sig_pi0 <= cfg_data;
                bcrs_pkg::REG_ETA_CENTER:  cfg_reg.eta_center  <= cfg_data;
                bcrs_pkg::REG_INV_SIG_ETA: cfg_reg.inv_sig_eta <= cfg_data;
                bcrs_pkg::REG_PI0_WIN_LO:  cfg_reg.pi0_win_lo  <= cfg_data;
                bcrs_pkg::REG_PI0_WIN_HI:  cfg_reg.pi0_win_hi  <= cfg_data;
                bcrs_pkg::REG_ETA_WIN_LO:  cfg_reg.eta_win_lo  <= cfg_data;
                bcrs_pkg::REG_ETA_WIN_HI:  cfg_reg.eta_win_hi  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    bcrs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .eta_pair_mass (eta_pair_mass),
        .pi0_pair_mass (pi0_pair_mass),
        .total_mass    (total_mass),
        .weight        (weight),
        .qstat         (qstat),
        .push          (push),
        .push_item     (push_item)
    );

    bcrs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    bcrs_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg_reg),
        .head                (head),
        .qstat               (qstat),
        .pop                 (pop),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .accepted            (accepted),
        .selected_total_mass (selected_total_mass),
        .selected_weight     (selected_weight),
        .selected_score      (selected_score)
    );

endmodule
`default_nettype wire
